FILE: design/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/dohl_pkg.sv
`default_nettype none

package dohl_pkg;

  // Frame kinds carried in obu_kind.
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_CLK    = 2'd1;
  localparam logic [1:0] KIND_SWITCH = 2'd2;
  localparam logic [1:0] KIND_SEF    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORDER_HINT_BITS = 2'd0;
  localparam logic [1:0] CFG_MLAYER_DEP      = 2'd1;
  localparam logic [1:0] CFG_TLAYER_DEP      = 2'd2;

  // Search query broadcast to every slot cell.
  typedef struct packed {
    logic [2:0]  mlayer;
    logic [2:0]  tlayer;
    logic [15:0] mlayer_dep;
    logic [63:0] tlayer_dep;
  } dohl_query_t;

  // Slot update broadcast after a result is formed.
  typedef struct packed {
    logic       en;
    logic       clear;
    logic       mark_rs;
    logic [2:0] mlayer;
    logic [2:0] tlayer;
  } dohl_upd_t;

endpackage

`default_nettype wire

FILE: design/dohl_cell.sv
`default_nettype none

module dohl_cell #(
  parameter int NUM_MLAYERS = 4,
  parameter int NUM_TLAYERS = 4,
  parameter int ORDER_WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dohl_pkg::dohl_query_t    query_i,
  input  dohl_pkg::dohl_upd_t      upd_i,
  input  logic                     refresh_i,
  input  logic [ORDER_WIDTH-1:0]   order_i,
  input  logic [ORDER_WIDTH-1:0]   best_i,
  output logic [ORDER_WIDTH-1:0]   best_o
);
  import dohl_pkg::*;

  logic                   valid_q, valid_d;
  logic                   rs_q, rs_d;
  logic [ORDER_WIDTH-1:0] order_q;
  logic [2:0]             ml_q;
  logic [2:0]             tl_q;
  logic [ORDER_WIDTH-1:0] best_q, best_d;

  logic       m_chk, t_chk, m_ok, t_ok, elig;
  logic [5:0] m_idx;
  logic [8:0] t_idx;
  logic [ORDER_WIDTH-1:0] cand;

  // Layer checks against the dependency maps.
  always_comb begin
    m_chk = ({1'b0, query_i.mlayer} < 4'(NUM_MLAYERS)) && ({1'b0, ml_q} < 4'(NUM_MLAYERS));
    t_chk = ({1'b0, query_i.mlayer} < 4'(NUM_MLAYERS)) &&
            ({1'b0, query_i.tlayer} < 4'(NUM_TLAYERS)) &&
            ({1'b0, tl_q} < 4'(NUM_TLAYERS));
    m_idx = 6'(query_i.mlayer) * 6'(NUM_MLAYERS) + 6'(ml_q);
    t_idx = (9'(query_i.mlayer) * 9'(NUM_TLAYERS) + 9'(query_i.tlayer)) * 9'(NUM_TLAYERS)
            + 9'(tl_q);
    m_ok  = !m_chk || ((m_idx < 6'd16) && query_i.mlayer_dep[m_idx[3:0]]);
    t_ok  = !t_chk || ((t_idx < 9'd64) && query_i.tlayer_dep[t_idx[5:0]]);
    elig  = valid_q && !rs_q && m_ok && t_ok;
    cand  = elig ? order_q : '0;
    best_d = (cand > best_i) ? cand : best_i;
  end

  // Slot flags: clear on CLK, mark on restricted switch, refresh last.
  always_comb begin
    valid_d = valid_q;
    rs_d    = rs_q;
    if (upd_i.en) begin
      if (upd_i.clear) begin
        valid_d = 1'b0;
        rs_d    = 1'b0;
      end
      if (upd_i.mark_rs && valid_d) begin
        rs_d = 1'b1;
      end
      if (refresh_i) begin
        valid_d = 1'b1;
        rs_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rs_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rs_q    <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (upd_i.en && refresh_i) begin
      order_q <= order_i;
      ml_q    <= upd_i.mlayer;
      tl_q    <= upd_i.tlayer;
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

FILE: design/display_order_hint_lifter.sv
// From request accept to result valid a request passes the scan, divide, lift and load steps.
// A new request is taken only once the last result has loaded; the reference search walks the
// slot cell chain one cell per cycle, so the slot count sets the pace.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_ni low, asynchronous): slots invalid, anchor cleared, config at defaults.
`default_nettype none

module display_order_hint_lifter #(
  parameter int NUM_SLOTS   = 8,
  parameter int NUM_MLAYERS = 4,
  parameter int NUM_TLAYERS = 4,
  parameter int ORDER_WIDTH = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  obu_kind_i,
  input  logic        frame_is_switch_i,
  input  logic        restricted_switch_i,
  input  logic [7:0]  order_hint_lsbs_i,
  input  logic [2:0]  mlayer_id_i,
  input  logic [2:0]  tlayer_id_i,
  input  logic [7:0]  refresh_flags_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [40:0] relative_order_o,
  output logic [39:0] lifted_order_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import dohl_pkg::*;

  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int OFW = ORDER_WIDTH + 2;           // signed offset
  localparam int QW  = ORDER_WIDTH + 1;           // quotient plus one
  localparam int SW  = ORDER_WIDTH + 17;          // lifted sum before saturation
  localparam int RW  = (ORDER_WIDTH + 1 > 41) ? ORDER_WIDTH + 1 : 41;
  localparam int LW  = (ORDER_WIDTH > 40) ? ORDER_WIDTH : 40;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_LIFT,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [3:0]  hint_bits_q;
  logic [15:0] mdep_q;
  logic [63:0] tdep_q;

  // Captured request.
  logic [1:0] kind_q;
  logic       raw_q;
  logic       rs_sw_q;
  logic [7:0] lsbs_q;
  logic [2:0] ml_q;
  logic [2:0] tl_q;
  logic [7:0] flags_q;

  logic [CW-1:0]          cnt_q;
  logic                   add_q;
  logic [QW-1:0]          quot_q;
  logic [ORDER_WIDTH-1:0] lifted_q;
  logic [ORDER_WIDTH-1:0] anchor_q;
  logic                   anchor_set_q;

  logic        out_valid_q;
  logic [40:0] rel_q;
  logic [39:0] lo_q;

  // Cell chain wiring.
  logic [ORDER_WIDTH-1:0] best_chain [NUM_SLOTS+1];
  dohl_query_t            query;
  dohl_upd_t              upd;
  logic                   out_free;
  logic                   load;

  // Lift arithmetic.
  logic [15:0]            half;
  logic signed [OFW-1:0]  offset;
  logic [ORDER_WIDTH-1:0] off_shr;
  logic [SW-1:0]          sum;
  logic [ORDER_WIDTH-1:0] sat;
  logic [ORDER_WIDTH-1:0] anchor_new;
  logic [RW-1:0]          diff;
  logic [LW-1:0]          lifted_ext;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign relative_order_o = rel_q;
  assign lifted_order_o   = lo_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == S_DONE) && out_free;

  // Broadcast the query; it holds still through the whole scan.
  assign query.mlayer     = ml_q;
  assign query.tlayer     = tl_q;
  assign query.mlayer_dep = mdep_q;
  assign query.tlayer_dep = tdep_q;

  // Slot update fires together with the result load.
  assign upd.en      = load;
  assign upd.clear   = (kind_q == KIND_CLK);
  assign upd.mark_rs = (kind_q == KIND_SWITCH) && rs_sw_q;
  assign upd.mlayer  = ml_q;
  assign upd.tlayer  = tl_q;

  // Row of slot cells; the running maximum advances one cell per cycle.
  assign best_chain[0] = '0;
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic refresh;
    if (g < 8) begin : g_flag
      assign refresh = flags_q[g];
    end else begin : g_noflag
      assign refresh = 1'b0;
    end
    dohl_cell #(
      .NUM_MLAYERS(NUM_MLAYERS),
      .NUM_TLAYERS(NUM_TLAYERS),
      .ORDER_WIDTH(ORDER_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .query_i   (query),
      .upd_i     (upd),
      .refresh_i (refresh),
      .order_i   (lifted_q),
      .best_i    (best_chain[g]),
      .best_o    (best_chain[g+1])
    );
  end

  always_comb begin
    // Half the wrap modulus; zero when the modulus is one.
    half    = (hint_bits_q == 4'd0) ? 16'd0 : (16'd1 << (hint_bits_q - 4'd1));
    offset  = $signed({2'b00, best_chain[NUM_SLOTS]}) - $signed(OFW'(half))
              - $signed(OFW'(lsbs_q));
    off_shr = offset[ORDER_WIDTH-1:0] >> hint_bits_q;
    sum     = SW'(lsbs_q) + (add_q ? (SW'(quot_q) << hint_bits_q) : SW'(0));
    // Saturate at the top of the order range.
    sat     = (|sum[SW-1:ORDER_WIDTH]) ? {ORDER_WIDTH{1'b1}} : sum[ORDER_WIDTH-1:0];
    anchor_new = anchor_set_q ? anchor_q : lifted_q;
    diff       = RW'(lifted_q) - RW'(anchor_new);
    lifted_ext = LW'(lifted_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hint_bits_q  <= 4'd7;
      mdep_q       <= 16'hFFFF;
      tdep_q       <= '1;
      kind_q       <= KIND_OTHER;
      raw_q        <= 1'b0;
      rs_sw_q      <= 1'b0;
      lsbs_q       <= '0;
      ml_q         <= '0;
      tl_q         <= '0;
      flags_q      <= '0;
      cnt_q        <= '0;
      add_q        <= 1'b0;
      quot_q       <= '0;
      lifted_q     <= '0;
      anchor_q     <= '0;
      anchor_set_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rel_q        <= '0;
      lo_q         <= '0;
    end else begin
      // Config writes are to arrive only while idle; the block itself does not enforce this.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ORDER_HINT_BITS: hint_bits_q <= cfg_data_i[3:0];
          CFG_MLAYER_DEP:      mdep_q      <= cfg_data_i[15:0];
          CFG_TLAYER_DEP:      tdep_q      <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the result once the consumer takes it, unless a new one loads now.
      if (out_valid_q && !out_stall_i && !load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= obu_kind_i;
            // CLK and restricted switch frames keep the raw bits; SEF never does.
            raw_q   <= (obu_kind_i == KIND_CLK) ||
                       ((obu_kind_i != KIND_SEF) && frame_is_switch_i && restricted_switch_i);
            rs_sw_q <= restricted_switch_i;
            lsbs_q  <= order_hint_lsbs_i;
            ml_q    <= mlayer_id_i;
            tl_q    <= tlayer_id_i;
            flags_q <= refresh_flags_i;
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance until the maximum has crossed the last cell.
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NUM_SLOTS - 1)) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          add_q   <= !raw_q && !offset[OFW-1];
          quot_q  <= QW'(off_shr) + QW'(1);
          state_q <= S_LIFT;
        end
        S_LIFT: begin
          lifted_q <= sat;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            anchor_q     <= anchor_new;
            anchor_set_q <= 1'b1;
            rel_q        <= diff[40:0];
            lo_q         <= lifted_ext[39:0];
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/dohl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dohl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [40:0] relative_order_o,
  input wire logic [39:0] lifted_order_o
);

  // The block goes busy right after taking a request.
  `ASSERT_NEXT(busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only follows a busy cycle.
  `ASSERT_SAME(result_after_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // A stalled result holds.
  `ASSERT_NEXT(result_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(lifted_order_o) && $stable(relative_order_o))

endmodule

bind display_order_hint_lifter dohl_checker u_dohl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .relative_order_o (relative_order_o),
  .lifted_order_o   (lifted_order_o)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dohl_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int NUM_MLAYERS = 4;
  localparam int NUM_TLAYERS = 4;
  localparam int ORDER_WIDTH = 40;

  localparam longint unsigned ORDER_MAX = (64'd1 << ORDER_WIDTH) - 64'd1;
  // Time one request takes through the block; allow for it when quiescing.
  localparam int BLOCK_CYCLES  = NUM_SLOTS + 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 138;
  localparam int CYCLE_LIMIT   = 400000;

  // One frame header request and the result it produces.
  typedef struct packed {
    bit [1:0] kind;
    bit       is_switch;
    bit       restricted;
    bit [7:0] lsbs;
    bit [2:0] mlayer;
    bit [2:0] tlayer;
    bit [7:0] refresh;
  } header_t;

  typedef struct packed {
    bit [40:0] relative;
    bit [39:0] lifted;
  } lifted_t;

  // Scoreboard: mirrors the slot table and anchor, predicts the lifted order of
  // every accepted request and checks results in order.
  class lift_scoreboard;
    bit [3:0]  hint_bits = 4'd7;
    bit [15:0] mlayer_map = 16'hFFFF;
    bit [63:0] tlayer_map = '1;
    bit        slot_valid      [NUM_SLOTS];
    bit        slot_restricted [NUM_SLOTS];
    bit [39:0] slot_order      [NUM_SLOTS];
    bit [2:0]  slot_mlayer     [NUM_SLOTS];
    bit [2:0]  slot_tlayer     [NUM_SLOTS];
    bit [39:0] anchor;
    bit        anchor_set;
    lifted_t   expected_orders [$];
    int unsigned fails;

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endtask

    function void write_reg(input logic [1:0] idx, input logic [63:0] data);
      case (idx)
        CFG_ORDER_HINT_BITS: hint_bits = data[3:0];
        CFG_MLAYER_DEP:      mlayer_map = data[15:0];
        CFG_TLAYER_DEP:      tlayer_map = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_orders.size();
    endfunction

    // Largest stored order among usable slots; zero when none qualifies.
    function bit [39:0] best_reference(input bit [2:0] ml, input bit [2:0] tl);
      bit [39:0] best;
      int idx;
      best = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_valid[i] || slot_restricted[i]) continue;
        if (ml < NUM_MLAYERS && slot_mlayer[i] < NUM_MLAYERS) begin
          idx = ml * NUM_MLAYERS + slot_mlayer[i];
          if (idx >= 16 || !mlayer_map[idx]) continue;
        end
        if (ml < NUM_MLAYERS && tl < NUM_TLAYERS && slot_tlayer[i] < NUM_TLAYERS) begin
          idx = (ml * NUM_TLAYERS + tl) * NUM_TLAYERS + slot_tlayer[i];
          if (idx >= 64 || !tlayer_map[idx]) continue;
        end
        if (slot_order[i] > best) best = slot_order[i];
      end
      return best;
    endfunction

    function void note_header(input header_t h);
      lifted_t res;
      longint unsigned lifted;
      longint unsigned modulus;
      longint best, half, raw, offset;
      int unsigned nbits;
      nbits  = hint_bits;
      lifted = h.lsbs;
      if (!(h.kind == KIND_CLK || (h.kind != KIND_SEF && h.is_switch && h.restricted))) begin
        modulus = (nbits == 0) ? 64'd1 : (64'd1 << nbits);
        best    = best_reference(h.mlayer, h.tlayer);
        half    = modulus >> 1;
        raw     = h.lsbs;
        offset  = best - half - raw;
        if (offset >= 0)
          lifted += (($unsigned(offset) >> nbits) + 64'd1) << nbits;
      end
      if (lifted > ORDER_MAX) lifted = ORDER_MAX;
      if (!anchor_set) begin
        anchor     = lifted[39:0];
        anchor_set = 1'b1;
      end
      // Slot updates take effect after the result is formed.
      if (h.kind == KIND_CLK) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot_valid[i]      = 1'b0;
          slot_restricted[i] = 1'b0;
        end
      end
      if (h.kind == KIND_SWITCH && h.restricted) begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_valid[i]) slot_restricted[i] = 1'b1;
      end
      for (int i = 0; i < NUM_SLOTS && i < 8; i++) begin
        if (h.refresh[i]) begin
          slot_valid[i]      = 1'b1;
          slot_restricted[i] = 1'b0;
          slot_order[i]      = lifted[39:0];
          slot_mlayer[i]     = h.mlayer;
          slot_tlayer[i]     = h.tlayer;
        end
      end
      res.lifted   = lifted[39:0];
      res.relative = lifted[40:0] - {1'b0, anchor};
      expected_orders.push_back(res);
    endfunction

    task check_result(input logic [40:0] relative, input logic [39:0] lifted);
      lifted_t want;
      if (expected_orders.size() == 0) begin
        report($sformatf("result with nothing outstanding, lifted_order=%0d", lifted));
        return;
      end
      want = expected_orders.pop_front();
      if (relative !== want.relative)
        report($sformatf("relative_order got %0d want %0d",
                         $signed(relative), $signed(want.relative)));
      if (lifted !== want.lifted)
        report($sformatf("lifted_order got %0d want %0d", lifted, want.lifted));
    endtask
  endclass

  // Clock, reset and block-side signals. Every input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic [1:0]  req_kind = KIND_OTHER;
  logic        req_switch = 1'b0;
  logic        req_restricted = 1'b0;
  logic [7:0]  req_lsbs = '0;
  logic [2:0]  req_mlayer = '0;
  logic [2:0]  req_tlayer = '0;
  logic [7:0]  req_refresh = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_ORDER_HINT_BITS;
  logic [63:0] cfg_data = '0;

  wire         in_stall_o;
  wire         out_valid_o;
  wire [40:0]  relative_order_o;
  wire [39:0]  lifted_order_o;
  wire         cfg_ready_o;

  lift_scoreboard sb = new;

  int unsigned     send_pct = 0;
  int unsigned     recv_pct = 0;
  int unsigned     hold_req = 0;
  int unsigned     cycle_count = 0;
  bit [3:0]        hint_bits_now = 4'd7;
  longint unsigned stream_order = 0;

  display_order_hint_lifter #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_MLAYERS(NUM_MLAYERS),
    .NUM_TLAYERS(NUM_TLAYERS),
    .ORDER_WIDTH(ORDER_WIDTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_stall_o         (in_stall_o),
    .obu_kind_i         (req_kind),
    .frame_is_switch_i  (req_switch),
    .restricted_switch_i(req_restricted),
    .order_hint_lsbs_i  (req_lsbs),
    .mlayer_id_i        (req_mlayer),
    .tlayer_id_i        (req_tlayer),
    .refresh_flags_i    (req_refresh),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .relative_order_o   (relative_order_o),
    .lifted_order_o     (lifted_order_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitor: everything here reads the values that held at the edge, so the
  // handshakes seen are exactly the ones the block saw. Register writes and
  // request accepts are applied before results are checked.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o === 1'b1)
        sb.write_reg(cfg_index, cfg_data);
      if (req_valid && in_stall_o === 1'b0)
        sb.note_header('{req_kind, req_switch, req_restricted, req_lsbs,
                         req_mlayer, req_tlayer, req_refresh});
      if (out_valid_o === 1'b1 && !out_stall)
        sb.check_result(relative_order_o, lifted_order_o);
    end
  end

  // Result side: stall at random, or hold off for a long stretch when the
  // stimulus asks for it, so the block backs up into its request port.
  initial begin : result_sink
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  function automatic header_t make_header(input bit [1:0] kind, input bit sw, input bit rs,
                                          input bit [7:0] lsbs, input bit [2:0] ml,
                                          input bit [2:0] tl, input bit [7:0] refresh);
    header_t h;
    h = '{kind, sw, rs, lsbs, ml, tl, refresh};
    return h;
  endfunction

  // Random request: mostly a plausible coded stream (advancing order hints,
  // occasional CLK, restricted switch and SEF units), the rest pure noise.
  function automatic header_t random_header();
    header_t h;
    int unsigned pick;
    longint unsigned wrap_mask;
    longint unsigned max_step;
    pick = $urandom_range(99);
    if (hint_bits_now >= 8) wrap_mask = 64'hFF;
    else                    wrap_mask = (64'd1 << hint_bits_now) - 64'd1;
    if (hint_bits_now == 0)     max_step = 1;
    else if (hint_bits_now > 8) max_step = 127;
    else                        max_step = ((64'd1 << hint_bits_now) >> 1) > 1 ?
                                           ((64'd1 << hint_bits_now) >> 1) - 1 : 1;
    h.kind       = 2'($urandom);
    h.is_switch  = 1'($urandom);
    h.restricted = 1'($urandom);
    h.lsbs       = 8'($urandom);
    h.mlayer     = 3'($urandom);
    h.tlayer     = 3'($urandom);
    h.refresh    = 8'($urandom);
    if (pick < 20) return h;
    // Keep layers mostly inside the dependency maps.
    if ($urandom_range(9) != 0) h.mlayer = 3'($urandom_range(NUM_MLAYERS - 1));
    if ($urandom_range(9) != 0) h.tlayer = 3'($urandom_range(NUM_TLAYERS - 1));
    if ($urandom_range(3) == 0) h.refresh = '0;
    if (pick < 25) begin
      h.kind       = KIND_CLK;
      stream_order = $urandom_range(255);
      h.refresh    = ($urandom_range(1) == 0) ? 8'hFF : h.refresh;
    end else begin
      stream_order += $urandom_range(int'(max_step), 1);
      if (pick < 30) begin
        h.kind       = KIND_SWITCH;
        h.restricted = 1'b1;
      end else if (pick < 34) begin
        h.kind = KIND_SEF;
      end else begin
        h.kind       = KIND_OTHER;
        h.is_switch  = ($urandom_range(7) == 0);
        h.restricted = h.is_switch & 1'($urandom);
      end
    end
    h.lsbs = 8'(stream_order & wrap_mask);
    return h;
  endfunction

  // Offer one request and hold it until accepted, then maybe idle.
  task automatic send_header(input header_t h);
    int gap;
    req_valid      <= 1'b1;
    req_kind       <= h.kind;
    req_switch     <= h.is_switch;
    req_restricted <= h.restricted;
    req_lsbs       <= h.lsbs;
    req_mlayer     <= h.mlayer;
    req_tlayer     <= h.tlayer;
    req_refresh    <= h.refresh;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding result, then idle a little.
  task automatic drain(input int tail);
    req_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only call with the block idle.
  task automatic write_config(input bit [3:0] bits, input bit [15:0] mlayer_map,
                              input bit [63:0] tlayer_map);
    logic [1:0]  idx [3];
    logic [63:0] val [3];
    idx[0] = CFG_ORDER_HINT_BITS; val[0] = 64'(bits);
    idx[1] = CFG_MLAYER_DEP;      val[1] = 64'(mlayer_map);
    idx[2] = CFG_TLAYER_DEP;      val[2] = tlayer_map;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    end
    cfg_valid     <= 1'b0;
    hint_bits_now  = bits;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_pct = 29; recv_pct <= 63; end
      1:       begin send_pct = 63; recv_pct <= 29; end
      default: begin send_pct = 0;  recv_pct <= 0;  end
    endcase
  endtask

  initial begin : stimulus
    bit [3:0]  bits;
    bit [15:0] mmap;
    bit [63:0] tmap;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    set_idling(0);
    write_config(4'd8, 16'hFFFF, '1);

    // Directed: empty table, first request sets the anchor.
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd255, 3'd0, 3'd0, 8'hFF));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd0, 3'd3, 3'd3, 8'h01));
    // SEF never takes the raw bits, even with both switch flags set.
    send_header(make_header(KIND_SEF, 1'b1, 1'b1, 8'd10, 3'd1, 3'd2, 8'h00));
    // Restricted switch frame: raw bits, lifted below the anchor.
    send_header(make_header(KIND_OTHER, 1'b1, 1'b1, 8'd5, 3'd0, 3'd0, 8'h00));
    // Restricted SWITCH unit without the switch frame type still marks slots.
    send_header(make_header(KIND_SWITCH, 1'b0, 1'b1, 8'd40, 3'd2, 3'd1, 8'h00));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd60, 3'd0, 3'd0, 8'h00));
    // Refresh clears the restricted mark of that slot.
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd70, 3'd1, 3'd1, 8'h80));
    send_header(make_header(KIND_SWITCH, 1'b1, 1'b1, 8'd128, 3'd0, 3'd0, 8'h03));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd200, 3'd2, 3'd3, 8'h00));
    // CLK: raw bits, table cleared, then refreshed with out-of-range layers.
    send_header(make_header(KIND_CLK, 1'b0, 1'b0, 8'd200, 3'd7, 3'd7, 8'h0F));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd20, 3'd7, 3'd7, 8'h10));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd90, 3'd2, 3'd5, 8'h20));
    send_header(make_header(KIND_CLK, 1'b0, 1'b0, 8'd0, 3'd0, 3'd0, 8'h00));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd255, 3'd3, 3'd0, 8'hFF));

    // Empty dependency maps and a one-element wrap.
    drain(BLOCK_CYCLES);
    write_config(4'd0, 16'h0000, 64'd0);
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd7, 3'd1, 3'd1, 8'h0F));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd0, 3'd5, 3'd2, 8'hF0));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd3, 3'd0, 3'd6, 8'h00));
    send_header(make_header(KIND_SEF, 1'b0, 1'b0, 8'd1, 3'd4, 3'd4, 8'h00));

    // Hint width beyond the coded field.
    drain(BLOCK_CYCLES);
    write_config(4'd15, 16'hA5C3, 64'hF0F0_3C3C_A5A5_0FF0);
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd255, 3'd0, 3'd0, 8'h55));
    send_header(make_header(KIND_SWITCH, 1'b1, 1'b0, 8'd0, 3'd1, 3'd3, 8'hAA));
    send_header(make_header(KIND_OTHER, 1'b0, 1'b0, 8'd128, 3'd3, 3'd1, 8'h00));
    send_header(make_header(KIND_SEF, 1'b1, 1'b1, 8'd200, 3'd2, 3'd2, 8'h01));

    // Random phases, each with its own register setting; phases run in pairs under one idling mode.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin bits = 4'd7;  mmap = 16'hFFFF;     tmap = '1; end
        1:       begin bits = 4'd8;  mmap = 16'($urandom); tmap = {$urandom, $urandom}; end
        2:       begin bits = 4'd0;  mmap = 16'h0000;     tmap = '0; end
        3:       begin bits = 4'd15; mmap = 16'hFFFF;     tmap = {$urandom, $urandom}; end
        4:       begin bits = 4'd3;  mmap = 16'($urandom); tmap = '1; end
        default: begin bits = 4'($urandom); mmap = 16'($urandom);
                       tmap = {$urandom, $urandom}; end
      endcase
      drain(BLOCK_CYCLES);
      write_config(bits, mmap, tmap);
      set_idling(phase / 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long result hold-off while requests keep coming.
        if ((phase == 0 || phase == 4) && n == 40) hold_req <= hold_req + 1;
        // Let the pipeline run dry mid-stream.
        if ((phase == 1 || phase == 3) && n == 60) drain(0);
        send_header(random_header());
      end
    end

    drain(2 * BLOCK_CYCLES);
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/dohl_pkg.sv
design/dohl_cell.sv
design/display_order_hint_lifter.sv
design/dohl_checker.sv
tb/sv/tb_top.sv
